// ===== sv/ard_pkg.sv =====
`default_nettype none

package ard_pkg;

    localparam int AXIS_W    = 13;
    localparam int SQ_W      = 25;
    localparam int MAG_W     = 26;
    localparam int THR_W     = 26;
    localparam int CNT_OUT_W = 16;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1300000);

    // floor(4*avg/5): reciprocal of five over the 4*avg range
    localparam int SCALE_W = MAG_W + 2;
    localparam logic [SCALE_W-1:0] DIV5_RECIP = SCALE_W'((64'd1 << SCALE_W) / 64'd5);
    localparam logic [SCALE_W-1:0] FIVE       = SCALE_W'(5);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef logic [MAG_W-1:0] t_mag;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic [CNT_OUT_W-1:0] count;
        logic                 start;
        logic                 in_rep;
        logic [THR_W-1:0]     thr;
        logic [MAG_W-1:0]     avg;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/accel_rep_detector_core.sv =====
// An accepted input beat passes the front register, the queue, the back pipeline and the output register.
// Throughput: one beat per cycle while neither side stalls; the front stage and the back pipeline are parted by a
// 4-entry queue and the output register, so each side stalls on its own.
// Reset (synchronous, active low): ring valid bits, running sum, peak, count and
// repetition flag clear; the threshold returns to 1300000. No clearing pass.
`default_nettype none

module accel_rep_detector_core
    import ard_pkg::*;
#(
    parameter int WINDOW     = 20,
    parameter int COUNT_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // accel_x[12:0], accel_y[25:13], accel_z[38:26], zero pad
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // average_level[25:0], current_threshold[51:26], in_repetition[52],
    // repetition_start[53], repetition_count[69:54], zero pad
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [THR_W-1:0]      i_cfg_data
);

    t_q_stat q_stat;
    logic    push;
    logic    pop;
    t_mag    front_mag;
    t_mag    q_mag;
    t_result result;

    ard_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_x     (i_s_axis_tdata[AXIS_W-1:0]),
        .i_y     (i_s_axis_tdata[2*AXIS_W-1:AXIS_W]),
        .i_z     (i_s_axis_tdata[3*AXIS_W-1:2*AXIS_W]),
        .i_q     (q_stat),
        .o_push  (push),
        .o_mag   (front_mag)
    );

    ard_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_mag),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_data  (q_mag)
    );

    ard_back #(
        .WINDOW     (WINDOW),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (q_stat),
        .i_mag       (q_mag),
        .o_pop       (pop),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (result)
    );

    assign o_m_axis_tdata = {(OUT_DATA_W - $bits(t_result))'(0), result};
    assign o_cfg_ready    = 1'b1;

endmodule

`default_nettype wire

// ===== sv/ard_front.sv =====
`default_nettype none

module ard_front
    import ard_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [AXIS_W-1:0]    i_x,
    input  wire logic [AXIS_W-1:0]    i_y,
    input  wire logic [AXIS_W-1:0]    i_z,
    input  wire t_q_stat              i_q,
    output logic                      o_push,
    output t_mag                      o_mag
);

    logic r_fv;
    t_mag r_mag;
    t_mag n_mag;
    logic [AXIS_W-1:0] ax, ay, az;
    logic [2*AXIS_W-1:0] sx, sy, sz;

    // magnitude of a two's complement axis; -4096 maps to 4096
    function automatic logic [AXIS_W-1:0] axis_abs(input logic [AXIS_W-1:0] v);
        return v[AXIS_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        ax = axis_abs(i_x);
        ay = axis_abs(i_y);
        az = axis_abs(i_z);
        sx = ax * ax;
        sy = ay * ay;
        sz = az * az;
        n_mag = MAG_W'(sx[SQ_W-1:0]) + MAG_W'(sy[SQ_W-1:0]) + MAG_W'(sz[SQ_W-1:0]);
    end

    assign o_push  = r_fv & ~i_q.full;
    assign o_ready = ~r_fv | ~i_q.full;
    assign o_mag   = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (o_ready) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_mag <= n_mag;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ard_queue.sv =====
`default_nettype none

module ard_queue
    import ard_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_mag  i_data,
    input  wire logic  i_pop,
    output t_q_stat    o_stat,
    output t_mag       o_data
);

    t_mag              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_stat.valid = (r_cnt != '0);
    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/ard_back.sv =====
`default_nettype none

module ard_back
    import ard_pkg::*;
#(
    parameter int WINDOW     = 20,
    parameter int COUNT_BITS = 16
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_q_stat          i_q,
    input  wire t_mag             i_mag,
    output logic                  o_pop,
    input  wire logic             i_cfg_valid,
    input  wire logic [THR_W-1:0] i_cfg_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_result               o_result
);

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUM_W = MAG_W + $clog2(WINDOW);
    localparam int PROD_W = 2 * SUM_W;
    localparam int PROD5_W = 2 * SCALE_W;
    localparam logic [63:0] RECIP_FULL = (64'd1 << SUM_W) / 64'(WINDOW);
    localparam logic [SUM_W-1:0] RECIP = RECIP_FULL[SUM_W-1:0];
    localparam logic [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);

    logic adv;

    // ring of squared magnitudes, one entry read ahead of use
    t_mag              r_ring [WINDOW];
    logic [WINDOW-1:0] r_rv;
    t_mag              r_rd;
    logic              r_rd_v;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    t_mag              old_mag;

    logic [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0] n_sum;
    logic             r_v1;

    logic [PROD_W-1:0] r_prod1;
    logic [SUM_W-1:0]  r_sum2;
    logic              r_v2;

    logic [SUM_W-1:0] q0;
    logic [SUM_W-1:0] rem;
    t_mag             n_avg;
    t_mag             r_avg3;
    logic             r_v3;

    logic [PROD5_W-1:0] r_prod2;
    t_mag               r_avg4;
    logic               r_v4;

    logic [SCALE_W-1:0] x4;
    logic [SCALE_W-1:0] q5;
    logic [SCALE_W-1:0] rem5;
    logic [THR_W-1:0]   n_favg;
    logic [THR_W-1:0]   r_favg5;
    t_mag               r_avg5;
    logic               r_v5;

    logic [THR_W-1:0]      r_pscaled;
    logic [THR_W-1:0]      n_pscaled;
    logic [THR_W-1:0]      r_thr;
    logic [THR_W-1:0]      n_thr;
    logic                  r_act;
    logic                  n_act;
    logic                  start;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] n_cnt;
    logic [COUNT_BITS+CNT_OUT_W-1:0] cnt_ext;

    logic    r_ov;
    t_result r_res;
    t_result n_res;

    assign adv   = ~r_ov | i_ready;
    assign o_pop = i_q.valid & adv;

    always_comb begin
        n_pos = r_pos;
        if (o_pop) begin
            n_pos = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
        end
        old_mag = r_rd_v ? r_rd : '0;
        n_sum   = r_sum - SUM_W'(old_mag) + SUM_W'(i_mag);
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ring[r_pos] <= i_mag;
        end
        r_rd <= r_ring[n_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv   <= '0;
            r_rd_v <= 1'b0;
            r_pos  <= '0;
            r_sum  <= '0;
            r_v1   <= 1'b0;
        end else begin
            r_rd_v <= r_rv[n_pos];
            r_pos  <= n_pos;
            if (o_pop) begin
                r_rv[r_pos] <= 1'b1;
                r_sum       <= n_sum;
            end
            if (adv) begin
                r_v1 <= i_q.valid;
            end
        end
    end

    // sum / WINDOW: reciprocal estimate is low by at most one
    always_comb begin
        q0    = r_prod1[PROD_W-1:SUM_W];
        rem   = r_sum2 - q0 * WIN_S;
        n_avg = q0[MAG_W-1:0] + MAG_W'(rem >= WIN_S);
    end

    // 4*avg / 5, same scheme
    always_comb begin
        x4     = {r_avg4, 2'b00};
        q5     = r_prod2[PROD5_W-1:SCALE_W];
        rem5   = x4 - q5 * FIVE;
        n_favg = q5[THR_W-1:0] + THR_W'(rem5 >= FIVE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod1 <= PROD_W'(r_sum) * PROD_W'(RECIP);
            r_sum2  <= r_sum;
            r_avg3  <= n_avg;
            r_prod2 <= PROD5_W'({r_avg3, 2'b00}) * PROD5_W'(DIV5_RECIP);
            r_avg4  <= r_avg3;
            r_favg5 <= n_favg;
            r_avg5  <= r_avg4;
        end
    end

    // peak tracked as its scaled value; floor(4x/5) is monotonic
    always_comb begin
        n_pscaled = (r_favg5 > r_pscaled) ? r_favg5 : r_pscaled;
        n_thr     = (n_pscaled > r_thr) ? n_pscaled : r_thr;
        start     = (r_avg5 > n_thr) & ~r_act;
        n_act     = r_act | start;
        if (r_avg5 < n_thr) begin
            n_act = 1'b0;
        end
        n_cnt   = r_cnt + COUNT_BITS'(start);
        cnt_ext = {{CNT_OUT_W{1'b0}}, n_cnt};
        n_res.avg    = r_avg5;
        n_res.thr    = n_thr;
        n_res.in_rep = n_act;
        n_res.start  = start;
        n_res.count  = cnt_ext[CNT_OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pscaled <= '0;
            r_thr     <= THR_RESET;
            r_act     <= 1'b0;
            r_cnt     <= '0;
            r_ov      <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= r_v5;
            end
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end else if (adv && r_v5) begin
                r_thr <= n_thr;
            end
            if (adv && r_v5) begin
                r_pscaled <= n_pscaled;
                r_act     <= n_act;
                r_cnt     <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_res;

endmodule

`default_nettype wire
